// ----- sv/slis_pkg.sv -----
// ----------------------------------------------------------------------------
// slis_pkg
// Shared types and constants for the sorted list insert/search block.
// ----------------------------------------------------------------------------
`default_nettype none

package slis_pkg;

  // Store depth and derived widths
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FIELD_W = 5;

  // Operation codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  // Engine sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  // Result of one transaction, engine to output stage
  typedef struct packed {
    logic               found;
    logic [FIELD_W-1:0] position;
    logic               dropped_full;
    logic [FIELD_W-1:0] stored_count;
  } result_t;

  // Fit a count into a result field (masked to the field width)
  function automatic logic [FIELD_W-1:0] fit_field(logic [CNT_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/slis_engine.sv -----
// ----------------------------------------------------------------------------
// slis_engine
// Entry store in a RAM with registered read plus the sequencer that walks it:
// inserts scan down from the top entry and shift as they go, searches scan up.
// ----------------------------------------------------------------------------
`default_nettype none

module slis_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          op_i,
  input  wire logic [slis_pkg::VALUE_W-1:0]  value_i,
  output      logic                          idle_o,
  output      logic                          res_valid_o,
  input  wire logic                          res_ready_i,
  output      slis_pkg::result_t             res_o
);

  slis_pkg::state_e state_q, state_d;

  logic [slis_pkg::CNT_W-1:0]   count_q, count_d;
  logic [slis_pkg::IDX_W-1:0]   cur_q, cur_d;
  logic                         op_q, op_d;
  logic [slis_pkg::VALUE_W-1:0] val_q, val_d;
  logic                         found_q, found_d;
  logic                         drop_q, drop_d;
  logic [slis_pkg::CNT_W-1:0]   pos_q, pos_d;

  // Entry RAM ports
  logic [slis_pkg::VALUE_W-1:0] mem [slis_pkg::DEPTH];
  logic [slis_pkg::VALUE_W-1:0] rdata_q;
  logic [slis_pkg::IDX_W-1:0]   rd_addr;
  logic                         mem_we;
  logic [slis_pkg::IDX_W-1:0]   wr_addr;
  logic [slis_pkg::VALUE_W-1:0] wr_data;

  logic                         is_full;
  logic                         is_empty;
  logic                         run_lt;
  logic                         run_eq;
  logic                         run_last;
  logic                         run_end;
  logic                         grows;
  logic [slis_pkg::CNT_W-1:0]   cur_ext;
  logic [slis_pkg::CNT_W-1:0]   next_count;

  assign is_full  = (count_q == slis_pkg::CNT_W'(slis_pkg::DEPTH));
  assign is_empty = (count_q == '0);
  assign cur_ext  = slis_pkg::CNT_W'(cur_q);

  // Compare the entry just read against the operand
  assign run_lt   = ($signed(rdata_q) < $signed(val_q));
  assign run_eq   = (rdata_q == val_q);
  assign run_last = (cur_ext + slis_pkg::CNT_W'(1)) == count_q;
  assign run_end  = (op_q == slis_pkg::OP_INSERT) ? (run_lt || (cur_q == '0))
                                                  : (run_eq || run_last);

  assign grows      = (op_q == slis_pkg::OP_INSERT) && !drop_q;
  assign next_count = count_q + (grows ? slis_pkg::CNT_W'(1) : '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      slis_pkg::ST_IDLE: begin
        if (start_i) begin
          if (is_empty || (op_i == slis_pkg::OP_INSERT && is_full)) begin
            state_d = slis_pkg::ST_DONE;
          end else begin
            state_d = slis_pkg::ST_RUN;
          end
        end
      end
      slis_pkg::ST_RUN: begin
        if (run_end) begin
          state_d = slis_pkg::ST_DONE;
        end
      end
      slis_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = slis_pkg::ST_IDLE;
        end
      end
      default: state_d = slis_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    count_d = count_q;
    cur_d   = cur_q;
    op_d    = op_q;
    val_d   = val_q;
    found_d = found_q;
    drop_d  = drop_q;
    pos_d   = pos_q;
    rd_addr = '0;
    mem_we  = 1'b0;
    wr_addr = '0;
    wr_data = val_q;
    case (state_q)
      slis_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d    = op_i;
          val_d   = value_i;
          found_d = 1'b0;
          drop_d  = 1'b0;
          pos_d   = '0;
          if (op_i == slis_pkg::OP_INSERT) begin
            // start the downward walk at the top entry
            drop_d  = is_full;
            cur_d   = slis_pkg::IDX_W'(count_q - slis_pkg::CNT_W'(1));
            rd_addr = slis_pkg::IDX_W'(count_q - slis_pkg::CNT_W'(1));
          end else begin
            cur_d   = '0;
            rd_addr = '0;
          end
        end
      end
      slis_pkg::ST_RUN: begin
        if (op_q == slis_pkg::OP_INSERT) begin
          if (run_lt) begin
            // new value lands just above this entry
            pos_d = cur_ext + slis_pkg::CNT_W'(1);
          end else begin
            // shift this entry up by one
            mem_we  = 1'b1;
            wr_addr = cur_q + slis_pkg::IDX_W'(1);
            wr_data = rdata_q;
            if (cur_q == '0) begin
              pos_d = '0;
            end else begin
              cur_d   = cur_q - slis_pkg::IDX_W'(1);
              rd_addr = cur_q - slis_pkg::IDX_W'(1);
            end
          end
        end else begin
          if (run_eq) begin
            found_d = 1'b1;
            pos_d   = cur_ext;
          end else if (run_last) begin
            pos_d = count_q;
          end else begin
            cur_d   = cur_q + slis_pkg::IDX_W'(1);
            rd_addr = cur_q + slis_pkg::IDX_W'(1);
          end
        end
      end
      slis_pkg::ST_DONE: begin
        // place the new value; repeating the write while stalled is harmless
        if (grows) begin
          mem_we  = 1'b1;
          wr_addr = pos_q[slis_pkg::IDX_W-1:0];
          wr_data = val_q;
        end
        if (res_ready_i) begin
          count_d = next_count;
        end
      end
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    idle_o                = (state_q == slis_pkg::ST_IDLE);
    res_valid_o           = (state_q == slis_pkg::ST_DONE);
    res_o.found           = found_q;
    res_o.position        = slis_pkg::fit_field(pos_q);
    res_o.dropped_full    = drop_q;
    res_o.stored_count    = slis_pkg::fit_field(next_count);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slis_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Operand and result registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    op_q    <= op_d;
    val_q   <= val_d;
    found_q <= found_d;
    drop_q  <= drop_d;
    pos_q   <= pos_d;
  end

  // Entry RAM, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- sv/sorted_list_insert_search.sv -----
// ----------------------------------------------------------------------------
// sorted_list_insert_search
// Ascending store of signed 32-bit values with ordered insert and first-match
// search, backed by a single entry RAM.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata                         | tuser
//  ---------+-----------+-------------------------------+-------------
//  s_axis   | in        | value[31:0]                   | operation
//  m_axis   | out       | found, position, dropped_full,| -
//           |           | stored_count (low bit up)     |
//
// A transaction needs no RAM walk when the store is empty or an insert finds it
// full; else an insert visits the entries from the top down to the first one
// below its value, and a search those up to its first match, so at most DEPTH
// entries are visited. The walk is paced by the registered RAM read. Reset
// empties the store at once. The next transaction is taken while a result
// waits in the output register; a stalled output holds the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_search (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] operation
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [15:0] m_axis_tdata_o    // [0] found, [5:1] position,
                                             // [6] dropped_full,
                                             // [11:7] stored_count, [15:12] 0
);

  logic              eng_idle;
  logic              eng_res_valid;
  logic              eng_res_ready;
  slis_pkg::result_t eng_res;

  logic              out_valid_q, out_valid_d;
  slis_pkg::result_t out_res_q;

  assign s_axis_tready_o = eng_idle;
  assign eng_res_ready   = !out_valid_q || m_axis_tready_i;

  slis_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid_i && eng_idle),
    .op_i        (s_axis_tuser_i[0]),
    .value_i     (s_axis_tdata_i),
    .idle_o      (eng_idle),
    .res_valid_o (eng_res_valid),
    .res_ready_i (eng_res_ready),
    .res_o       (eng_res)
  );

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (eng_res_valid && eng_res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (eng_res_valid && eng_res_ready) begin
      out_res_q <= eng_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000,
                            out_res_q.stored_count,
                            out_res_q.dropped_full,
                            out_res_q.position,
                            out_res_q.found};

endmodule

`default_nettype wire

// ----- dv/sorted_list_insert_search_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_list_insert_search_test
// Self-checking bench for the sorted list insert/search block. A queue of
// insert and search transactions feeds a bursty stream driver. A shadow copy
// of the ascending store predicts each result at input acceptance, and a
// monitor behind a stalling receiver checks every result field in order.
// ----------------------------------------------------------------------------

module sorted_list_insert_search_test;
  import slis_pkg::*;

  // One queued input transaction; drain_first holds it until all results land
  typedef struct {
    op_e         op;
    logic [31:0] value;
    bit          drain_first;
  } list_op_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;   // [31:0] value
  logic [0:0]  s_axis_tuser_i  = '0;   // [0] operation
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;         // [0] found, [5:1] position,
                                       // [6] dropped_full, [11:7] stored_count

  sorted_list_insert_search DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  list_op_t        op_queue[$];
  result_t         outcome_q[$];
  logic [31:0]     held_values[$];   // values inserted so far, for stimulus
  int              failures = 0;

  // Shadow store of the block
  logic signed [31:0] shelf [DEPTH];
  int unsigned        shelf_count = 0;

  // Apply one transaction to the shadow store and return its result
  function automatic result_t apply_list_op(op_e op, logic signed [31:0] v);
    result_t     r;
    int unsigned slot;
    r = '0;
    slot = shelf_count;
    if (op == OP_INSERT) begin
      if (shelf_count >= DEPTH) begin
        r.dropped_full = 1'b1;
        slot = 0;
      end else begin
        for (int i = 0; i < shelf_count; i++) begin
          if (!(shelf[i] < v)) begin
            slot = i;
            break;
          end
        end
        for (int i = shelf_count; i > slot; i--) shelf[i] = shelf[i-1];
        shelf[slot] = v;
        shelf_count++;
      end
    end else begin
      for (int i = 0; i < shelf_count; i++) begin
        if (shelf[i] == v) begin
          r.found = 1'b1;
          slot = i;
          break;
        end
      end
    end
    r.position     = slot[FIELD_W-1:0];
    r.stored_count = shelf_count[FIELD_W-1:0];
    return r;
  endfunction

  // Append one transaction and track what the store will hold
  task automatic queue_op(op_e op, logic [31:0] v, bit drain);
    list_op_t t;
    t.op = op;
    t.value = v;
    t.drain_first = drain;
    op_queue.push_back(t);
    if (op == OP_INSERT && held_values.size() < DEPTH) held_values.push_back(v);
  endtask

  // Driver: bursts of transactions with random gaps between them
  list_op_t next_op;
  int       burst_left = 0;
  int       gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        outcome_q.push_back(apply_list_op(op_e'(s_axis_tuser_i[0]), s_axis_tdata_i));
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (op_queue.size() > 0 &&
                     (!op_queue[0].drain_first || outcome_q.size() == 0)) begin
          next_op = op_queue.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= next_op.value;
          s_axis_tuser_i  <= next_op.op;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: receiver stall pattern rotates through four patterns
  int unsigned rx_cycle = 0;
  result_t     want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      rx_cycle++;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (outcome_q.size() == 0) begin
          $error("result with no transaction pending: tdata %h", m_axis_tdata_o);
          failures++;
        end else begin
          want = outcome_q.pop_front();
          if (m_axis_tdata_o[0] !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, m_axis_tdata_o[0]);
            failures++;
          end
          if (m_axis_tdata_o[5:1] !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, m_axis_tdata_o[5:1]);
            failures++;
          end
          if (m_axis_tdata_o[6] !== want.dropped_full) begin
            $error("dropped_full: expected %0d, got %0d", want.dropped_full,
                   m_axis_tdata_o[6]);
            failures++;
          end
          if (m_axis_tdata_o[11:7] !== want.stored_count) begin
            $error("stored_count: expected %0d, got %0d", want.stored_count,
                   m_axis_tdata_o[11:7]);
            failures++;
          end
        end
      end
      case ((rx_cycle >> 8) % 4)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready_i <= ((rx_cycle % 7) < 2);
      endcase
    end
  end

  // Stimulus, reset and end of run
  logic [31:0] v;
  int          pick;
  op_e         op;

  initial begin
    // Directed: empty store, extremes, equal values, hits and misses
    queue_op(OP_SEARCH, 32'h0000_0000, 1'b0);
    queue_op(OP_SEARCH, 32'h8000_0000, 1'b0);
    queue_op(OP_INSERT, 32'h0000_0000, 1'b0);
    queue_op(OP_INSERT, 32'h7FFF_FFFF, 1'b0);
    queue_op(OP_INSERT, 32'h8000_0000, 1'b0);
    queue_op(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
    queue_op(OP_INSERT, 32'h0000_0000, 1'b0);
    queue_op(OP_SEARCH, 32'h0000_0000, 1'b0);
    queue_op(OP_SEARCH, 32'h7FFF_FFFF, 1'b0);
    queue_op(OP_SEARCH, 32'h8000_0000, 1'b0);
    queue_op(OP_SEARCH, 32'hFFFF_FFFF, 1'b0);
    queue_op(OP_SEARCH, 32'h0000_0001, 1'b0);
    queue_op(OP_SEARCH, 32'h7FFF_FFFE, 1'b0);
    queue_op(OP_INSERT, 32'h7FFF_FFFF, 1'b0);
    queue_op(OP_INSERT, 32'h5555_5555, 1'b0);
    queue_op(OP_INSERT, 32'hAAAA_AAAA, 1'b0);
    queue_op(OP_SEARCH, 32'h5555_5555, 1'b1);
    queue_op(OP_SEARCH, 32'hAAAA_AAAA, 1'b0);
    queue_op(OP_SEARCH, 32'h7FFF_FFFF, 1'b0);

    // Random: mixed ops until full, then mostly searches plus refused inserts
    for (int n = 0; n < 700; n++) begin
      if (held_values.size() < DEPTH)
        op = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_SEARCH;
      else
        op = ($urandom_range(0, 9) == 0) ? OP_INSERT : OP_SEARCH;
      pick = $urandom_range(0, 99);
      if (pick < 40 && held_values.size() > 0)
        v = held_values[$urandom_range(0, held_values.size() - 1)];
      else if (pick < 55 && held_values.size() > 0)
        v = held_values[$urandom_range(0, held_values.size() - 1)] +
            (($urandom_range(0, 1) == 0) ? 32'd1 : 32'hFFFF_FFFF);
      else if (pick < 65)
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      else
        v = $urandom;
      queue_op(op, v, (n == 350));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample between edges so driver and monitor updates have settled
    while (op_queue.size() > 0 || s_axis_tvalid_i || outcome_q.size() > 0)
      @(negedge clk_i);
    repeat (4 * (DEPTH + 2)) @(posedge clk_i);

    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
sv/slis_pkg.sv
sv/slis_engine.sv
sv/sorted_list_insert_search.sv
dv/sorted_list_insert_search_test.sv
